// ----- rtl/llkc_pkg.sv -----
// Shared types, keyword table and helpers for the log line keyword classifier.
`timescale 1ns / 1ps

package llkc_pkg;

  // Window and keyword table sizes.
  localparam int unsigned WinDepth = 9;
  localparam int unsigned KwCount  = 21;
  localparam int unsigned KwMaxLen = 10;

  typedef logic [7:0]  char_t;
  typedef logic [15:0] pos_t;
  typedef logic [3:0]  kwlen_t;
  typedef logic [3:0]  fill_t;
  typedef logic [2:0]  class_t;

  // The byte position stops counting at this value.
  localparam pos_t MaxLineLength = 16'hFFFF;

  // Severity classes as they appear on the output.
  localparam class_t ClsNone     = 3'd0;
  localparam class_t ClsCritical = 3'd1;
  localparam class_t ClsError    = 3'd2;
  localparam class_t ClsWarning  = 3'd3;
  localparam class_t ClsSuccess  = 3'd4;
  localparam class_t ClsInfo     = 3'd5;

  // Keyword text, right aligned: the last character sits in bits [7:0].
  localparam logic [KwMaxLen*8-1:0] KwText [KwCount] = '{
    "[critical]", "critical", "fatal",
    "[error]", "error",
    "[warning]", "warning",
    "[success]", "success", "succeed", "done", "ok ", "ok:", "[ok]",
    "[info]", "info", "[display]", "display", "[log]", "log:", "log "
  };

  localparam kwlen_t KwLen [KwCount] = '{
    4'd10, 4'd8, 4'd5,
    4'd7, 4'd5,
    4'd9, 4'd7,
    4'd9, 4'd7, 4'd7, 4'd4, 4'd3, 4'd3, 4'd4,
    4'd6, 4'd4, 4'd9, 4'd7, 4'd5, 4'd4, 4'd4
  };

  localparam class_t KwClass [KwCount] = '{
    ClsCritical, ClsCritical, ClsCritical,
    ClsError, ClsError,
    ClsWarning, ClsWarning,
    ClsSuccess, ClsSuccess, ClsSuccess, ClsSuccess, ClsSuccess, ClsSuccess, ClsSuccess,
    ClsInfo, ClsInfo, ClsInfo, ClsInfo, ClsInfo, ClsInfo, ClsInfo
  };

  // Result of matching all keywords that end at the current byte.
  typedef struct packed {
    logic   hit;
    kwlen_t len;
    class_t cls;
  } kw_match_t;

  // ASCII lowercase: only 'A'..'Z' are changed.
  function automatic char_t to_lower(char_t c);
    char_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- rtl/log_line_keyword_classifier_top.sv -----
// Top level of the log line keyword classifier.
//
//   Channel | Direction | Handshake                  | Payload
//   input   | in        | in_valid_i / in_ready_o    | text_byte_i, end_of_line_i
//   output  | out       | out_valid_o / out_ready_i  | severity_class_o
//
// One byte is taken per cycle unless a line end is stalled. A byte is
// registered on entry and matched in the next cycle against the nine-byte
// window; a line end then passes from the input register to the result
// register, which raises out_valid_o. Only a line end waits on a full result
// register; other bytes keep flowing while a result is stalled.
// Reset clears the line state; no clearing pass is needed.
`timescale 1ns / 1ps

module log_line_keyword_classifier_top
  import llkc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] severity_class_o
);

  // Input register.
  logic  s1_valid_q, s1_valid_d;
  char_t s1_byte_q;
  logic  s1_eol_q;

  // Line state.
  char_t  win_q [WinDepth];
  fill_t  fill_q, fill_d;
  pos_t   pos_q, pos_d;
  pos_t   best_start_q, best_start_d;
  class_t best_class_q, best_class_d;

  // Result register.
  logic   out_valid_q, out_valid_d;
  class_t out_class_q;

  kw_match_t match;
  pos_t      len_m1;
  pos_t      start;
  logic      take;
  logic      proc;
  logic      in_req;

  // A line end can only move on when the result register is free.
  assign proc       = s1_valid_q && (!s1_eol_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || proc;
  assign in_req     = in_valid_i && in_ready_o;

  llkc_matcher u_matcher (
    .cur_i    (s1_byte_q),
    .window_i (win_q),
    .fill_i   (fill_q),
    .match_o  (match)
  );

  // Start of the keyword that ends here, clamped at zero.
  assign len_m1 = {12'd0, match.len} - 16'd1;
  assign start  = (pos_q >= len_m1) ? (pos_q - len_m1) : '0;
  assign take   = match.hit && (start < best_start_q);

  // Next line state: update on a byte, back to reset values at a line end.
  always_comb begin
    fill_d       = fill_q;
    pos_d        = pos_q;
    best_start_d = best_start_q;
    best_class_d = best_class_q;
    if (proc) begin
      if (s1_eol_q) begin
        fill_d       = '0;
        pos_d        = '0;
        best_start_d = '1;
        best_class_d = ClsNone;
      end else begin
        if (fill_q < fill_t'(WinDepth)) begin
          fill_d = fill_q + 4'd1;
        end
        if (pos_q < MaxLineLength) begin
          pos_d = pos_q + 16'd1;
        end
        if (take) begin
          best_start_d = start;
          best_class_d = match.cls;
        end
      end
    end
  end

  // Valid flags of the two registers.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_req) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc && s1_eol_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fill_q       <= '0;
      pos_q        <= '0;
      best_start_q <= '1;
      best_class_q <= ClsNone;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      fill_q       <= fill_d;
      pos_q        <= pos_d;
      best_start_q <= best_start_d;
      best_class_q <= best_class_d;
    end
  end

  // Payload registers; the window is gated by the fill count.
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      s1_byte_q <= to_lower(text_byte_i);
      s1_eol_q  <= end_of_line_i;
    end
    if (proc && !s1_eol_q) begin
      win_q[0] <= s1_byte_q;
      for (int i = 1; i < WinDepth; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
    if (proc && s1_eol_q) begin
      out_class_q <= take ? match.cls : best_class_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign severity_class_o = out_class_q;

endmodule

// ----- rtl/llkc_matcher.sv -----
// Parallel comparison of the byte window against the keyword table.
`timescale 1ns / 1ps

module llkc_matcher
  import llkc_pkg::*;
(
  input  char_t     cur_i,
  input  char_t     window_i [WinDepth],
  input  fill_t     fill_i,
  output kw_match_t match_o
);

  char_t seq [KwMaxLen];
  logic  hit [KwCount];

  // Oldest bytes at the high end; seq[0] is the byte being matched.
  always_comb begin
    seq[0] = cur_i;
    for (int i = 0; i < WinDepth; i++) begin
      seq[i+1] = window_i[i];
    end
  end

  // Every keyword is compared at once. No keyword is a suffix of another,
  // so at most one can end at a given byte and the hits are simply ORed.
  always_comb begin
    match_o = '0;
    for (int k = 0; k < KwCount; k++) begin
      hit[k] = ({1'b0, fill_i} + 5'd1) >= {1'b0, KwLen[k]};
      for (int e = 0; e < KwMaxLen; e++) begin
        if (e < int'(KwLen[k])) begin
          hit[k] = hit[k] && (seq[e] == KwText[k][e*8 +: 8]);
        end
      end
      if (hit[k]) begin
        match_o.hit = 1'b1;
        match_o.len = match_o.len | KwLen[k];
        match_o.cls = match_o.cls | KwClass[k];
      end
    end
  end

endmodule

// ----- rtl/llkc_checker.sv -----
// Port-level checks for the log line keyword classifier, bound to the top level.
`timescale 1ns / 1ps

module llkc_port_checker
  import llkc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       end_of_line_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] severity_class_o
);

  // A stalled result keeps its class.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(severity_class_o))
    else $error("result changed while stalled");

  // A new result follows a line end request taken earlier at the input.
  a_result_from_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && end_of_line_i, 2))
    else $error("result without a line end request");

  // With the result register empty, nothing can hold up the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

  // Only the six defined classes are reported.
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> severity_class_o <= ClsInfo)
    else $error("class code out of range");

endmodule

bind log_line_keyword_classifier_top llkc_port_checker u_llkc_port_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .end_of_line_i    (end_of_line_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .severity_class_o (severity_class_o)
);
